FILE: rtl/mono_framebuffer_pixel_line_engine_defines.svh
// Assertion macros shared by the frame store engine modules.
`ifndef MONO_FRAMEBUFFER_PIXEL_LINE_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_PIXEL_LINE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define MFB_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFB_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MFB_ASSERT_CLK(lbl, prop, msg)
`define MFB_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: rtl/mfb_pkg.sv
// Package with panel geometry, operation codes, states and control structs.
package mfb_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_ROWS    = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_ROWS;
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  localparam int OP_W    = 3;
  localparam int COORD_W = 11;
  localparam int IDX_W   = 10;
  localparam int DATA_W  = 8;
  localparam int ERR_W   = COORD_W + 3;

  typedef enum logic [OP_W-1:0] {
    OP_SET_PIXEL   = 3'd0,
    OP_CLEAR_PIXEL = 3'd1,
    OP_DRAW_LINE   = 3'd2,
    OP_READ_BYTE   = 3'd3,
    OP_POLL_DIRTY  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIXEL,
    ST_LINE,
    ST_READ,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic plot;
    logic step;
    logic line_end;
    logic rd_issue;
    logic clr;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_end;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/mfb_ctrl.sv
// Controller state machine that sequences clearing, plotting, reads and results.
`include "mono_framebuffer_pixel_line_engine_defines.svh"

module mfb_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [mfb_pkg::OP_W-1:0]     in_operation,
  output logic                         in_stall,
  input  mfb_pkg::dp_status_t          status_i,
  output mfb_pkg::ctrl_cmd_t           cmd_o
);

  mfb_pkg::state_t state_r;
  mfb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfb_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_stall  = (state_r != mfb_pkg::ST_IDLE);
    case (state_r)
      mfb_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_nxt = mfb_pkg::ST_IDLE;
        end
      end
      mfb_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          case (in_operation)
            mfb_pkg::OP_SET_PIXEL:   state_nxt = mfb_pkg::ST_PIXEL;
            mfb_pkg::OP_CLEAR_PIXEL: state_nxt = mfb_pkg::ST_PIXEL;
            mfb_pkg::OP_DRAW_LINE:   state_nxt = mfb_pkg::ST_LINE;
            mfb_pkg::OP_READ_BYTE:   state_nxt = mfb_pkg::ST_READ;
            default:                 state_nxt = mfb_pkg::ST_RESULT;
          endcase
        end
      end
      mfb_pkg::ST_PIXEL: begin
        cmd_o.plot = 1'b1;
        state_nxt  = mfb_pkg::ST_DRAIN;
      end
      mfb_pkg::ST_LINE: begin
        cmd_o.plot = 1'b1;
        if (status_i.at_end) begin
          cmd_o.line_end = 1'b1;
          state_nxt      = mfb_pkg::ST_DRAIN;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      mfb_pkg::ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_nxt      = mfb_pkg::ST_RESULT;
      end
      mfb_pkg::ST_DRAIN: begin
        // The last pixel's write lands in this cycle, so the result can go out now.
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = mfb_pkg::ST_IDLE;
        end else begin
          state_nxt = mfb_pkg::ST_RESULT;
        end
      end
      mfb_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = mfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mfb_pkg::ST_IDLE;
      end
    endcase
  end

  `MFB_ASSERT_NEVER(a_step_past_end, cmd_o.step && status_i.at_end, "line stepped past its end")
  `MFB_ASSERT_CLK(a_clear_then_idle, (state_r == mfb_pkg::ST_CLEAR) && status_i.clr_last |=> (state_r == mfb_pkg::ST_IDLE), "clear pass did not end in idle")
  `MFB_ASSERT_CLK(a_line_end_drains, cmd_o.line_end |=> (state_r == mfb_pkg::ST_DRAIN), "line end not followed by drain")

endmodule

FILE: rtl/mfb_datapath.sv
// Datapath: frame store memory, line stepper, pixel read-modify-write and result register.
`include "mono_framebuffer_pixel_line_engine_defines.svh"

module mfb_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [mfb_pkg::OP_W-1:0]             in_operation,
  input  logic signed [mfb_pkg::COORD_W-1:0]   in_x_start,
  input  logic signed [mfb_pkg::COORD_W-1:0]   in_y_start,
  input  logic signed [mfb_pkg::COORD_W-1:0]   in_x_end,
  input  logic signed [mfb_pkg::COORD_W-1:0]   in_y_end,
  input  logic [mfb_pkg::IDX_W-1:0]            in_byte_index,
  input  mfb_pkg::ctrl_cmd_t                   cmd_i,
  output mfb_pkg::dp_status_t                  status_o,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [mfb_pkg::DATA_W-1:0]           out_read_data,
  output logic                                 out_dirty
);

  localparam int CW = mfb_pkg::COORD_W;
  localparam int EW = mfb_pkg::ERR_W;
  localparam int AW = mfb_pkg::ADDR_W;
  localparam int DW = mfb_pkg::DATA_W;

  // Captured operation.
  mfb_pkg::op_t            op_r;
  logic [mfb_pkg::IDX_W-1:0] idx_r;
  logic                    idx_ok_r;

  // Line stepper registers.
  logic signed [CW-1:0] x_r, y_r, xe_r, ye_r;
  logic signed [EW-1:0] dx_r, dy_r, err_r;
  logic                 sx_r, sy_r;

  // Pixel pipeline: read issued, then merge and write in the next cycle.
  logic          s1_valid_r;
  logic [AW-1:0] s1_addr_r;
  logic [2:0]    s1_bit_r;
  logic          s1_val_r;
  logic [DW-1:0] rdata_r;
  logic          wr_valid_r;
  logic [AW-1:0] wr_addr_r;
  logic [DW-1:0] wr_data_r;

  logic [AW-1:0] clr_cnt_r;
  logic          dirty_r;
  logic          out_valid_r;
  logic [DW-1:0] out_data_r;
  logic          out_dirty_r;

  logic [DW-1:0] mem [mfb_pkg::STORE_BYTES];

  // Capture arithmetic.
  logic signed [CW:0]   ddx, ddy;
  logic signed [CW:0]   adx, ady;
  // Stepper arithmetic.
  logic signed [EW:0]   e2, dx_w, dy_w;
  logic                 go_x, go_y;
  logic signed [EW-1:0] err_nxt;
  // Pixel address.
  logic                 on_panel;
  logic [AW-1:0]        pix_addr;
  logic [CW-4:0]        page;
  logic [DW-1:0]        base, merged;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [DW-1:0]        wr_data;
  logic                 out_free;

  assign ddx = (CW+1)'(in_x_end) - (CW+1)'(in_x_start);
  assign ddy = (CW+1)'(in_y_end) - (CW+1)'(in_y_start);
  assign adx = ddx[CW] ? -ddx : ddx;
  assign ady = ddy[CW] ? -ddy : ddy;

  assign e2      = {err_r, 1'b0};
  assign dx_w    = (EW+1)'(dx_r);
  assign dy_w    = (EW+1)'(dy_r);
  assign go_x    = (e2 >= dy_w);
  assign go_y    = (e2 <= dx_w);
  assign err_nxt = err_r + (go_x ? dy_r : EW'(0)) + (go_y ? dx_r : EW'(0));

  assign on_panel = !x_r[CW-1] && !y_r[CW-1]
                    && ($unsigned(x_r) < CW'(mfb_pkg::PANEL_WIDTH))
                    && ($unsigned(y_r) < CW'(mfb_pkg::PANEL_HEIGHT));
  assign page     = y_r[CW-1:3];
  assign pix_addr = AW'($unsigned(x_r)) + AW'(32'(page) * mfb_pkg::PANEL_WIDTH);

  // The previous cycle's write may target the byte just read; take it from the bypass.
  assign base   = (wr_valid_r && (wr_addr_r == s1_addr_r)) ? wr_data_r : rdata_r;
  assign merged = s1_val_r ? (base | (DW'(1) << s1_bit_r))
                           : (base & ~(DW'(1) << s1_bit_r));

  assign rd_en   = (cmd_i.plot && on_panel) || cmd_i.rd_issue;
  assign rd_addr = cmd_i.rd_issue ? AW'(idx_r) : pix_addr;
  assign wr_en   = cmd_i.clr || s1_valid_r;
  assign wr_addr = cmd_i.clr ? clr_cnt_r : s1_addr_r;
  assign wr_data = cmd_i.clr ? DW'(0) : merged;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      wr_valid_r  <= 1'b0;
      clr_cnt_r   <= '0;
      dirty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd_i.plot && on_panel;
      wr_valid_r <= s1_valid_r && !cmd_i.clr;
      if (cmd_i.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd_i.finish && (op_r == mfb_pkg::OP_POLL_DIRTY)) begin
        dirty_r <= 1'b0;
      end else if ((cmd_i.plot && on_panel) || cmd_i.line_end) begin
        dirty_r <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= pix_addr;
    s1_bit_r  <= y_r[2:0];
    s1_val_r  <= (op_r != mfb_pkg::OP_CLEAR_PIXEL);
    wr_addr_r <= s1_addr_r;
    wr_data_r <= merged;
    if (cmd_i.capture) begin
      op_r     <= mfb_pkg::op_t'(in_operation);
      idx_r    <= in_byte_index;
      idx_ok_r <= (32'(in_byte_index) < mfb_pkg::STORE_BYTES);
      x_r      <= in_x_start;
      y_r      <= in_y_start;
      xe_r     <= in_x_end;
      ye_r     <= in_y_end;
      dx_r     <= EW'(adx);
      dy_r     <= -EW'(ady);
      err_r    <= EW'(adx) - EW'(ady);
      sx_r     <= (in_x_start < in_x_end);
      sy_r     <= (in_y_start < in_y_end);
    end else if (cmd_i.step) begin
      err_r <= err_nxt;
      if (go_x) begin
        x_r <= sx_r ? x_r + CW'(1) : x_r - CW'(1);
      end
      if (go_y) begin
        y_r <= sy_r ? y_r + CW'(1) : y_r - CW'(1);
      end
    end
    if (cmd_i.finish) begin
      out_data_r  <= ((op_r == mfb_pkg::OP_READ_BYTE) && idx_ok_r) ? rdata_r : DW'(0);
      out_dirty_r <= dirty_r;
    end
  end

  assign status_o.at_end   = (x_r == xe_r) && (y_r == ye_r);
  assign status_o.clr_last = (clr_cnt_r == AW'(mfb_pkg::STORE_BYTES - 1));
  assign status_o.out_free = out_free;

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_dirty     = out_dirty_r;

  `MFB_ASSERT_CLK(a_finish_needs_slot, cmd_i.finish |-> (!out_valid_r || !out_stall), "result loaded over a waiting beat")
  `MFB_ASSERT_NEVER(a_one_read_source, cmd_i.plot && cmd_i.rd_issue, "two reads issued in one cycle")
  `MFB_ASSERT_CLK(a_clear_no_pixel, cmd_i.clr |-> !s1_valid_r, "pixel write during clear pass")

endmodule

FILE: rtl/mono_framebuffer_pixel_line_engine.sv
// Top level of the page-layout monochrome frame store with pixel and line engine.
// After reset the block sweeps all STORE_BYTES bytes of the frame store (1024 for a
// 128 x 64 panel) to zero, one byte per cycle, and holds in_stall high meanwhile.
// Each accepted beat then yields exactly one result beat. A line walks every point,
// on-panel or not, and a pixel or line then passes a drain state before its result.
// The frame store has one read port and one write port: a pixel is read in one
// cycle and merged and written back in the next, with a bypass so that the line
// stepper can issue one point per cycle. A result waiting on out_stall does not
// block the next beat from being accepted.
module mono_framebuffer_pixel_line_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mfb_pkg::OP_W-1:0]             in_operation,
  input  logic signed [mfb_pkg::COORD_W-1:0]   in_x_start,
  input  logic signed [mfb_pkg::COORD_W-1:0]   in_y_start,
  input  logic signed [mfb_pkg::COORD_W-1:0]   in_x_end,
  input  logic signed [mfb_pkg::COORD_W-1:0]   in_y_end,
  input  logic [mfb_pkg::IDX_W-1:0]            in_byte_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mfb_pkg::DATA_W-1:0]           out_read_data,
  output logic                                 out_dirty
);

  mfb_pkg::ctrl_cmd_t  cmd;
  mfb_pkg::dp_status_t status;

  mfb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  mfb_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_operation  (in_operation),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_byte_index (in_byte_index),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_dirty     (out_dirty)
  );

endmodule
